/* rtl/rti_pkg.sv */
`default_nettype none
package rti_pkg;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  row_sel;
        logic [3:0]  column_sel;
        logic [15:0] write_word;
        logic [15:0] level;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  value_index;
        logic [15:0] result_value;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_DROP   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  row_sel;
        logic [3:0]  column_sel;
        logic [15:0] write_word;
        logic [15:0] level;
    } q_item_t;

    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [1:0] ST_COPY    = 2'd0;
    localparam logic [1:0] ST_INTERP  = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    localparam logic CFG_IDX_ROWS   = 1'b0;
    localparam logic CFG_IDX_VALUES = 1'b1;
    localparam int   CFG_W          = 5;

    localparam logic [4:0] ROWS_RESET   = 5'd16;
    localparam logic [3:0] VALUES_RESET = 4'd8;

    // round up when the fraction reaches ROUND_NUM / ROUND_DEN for rising values, and only when it exceeds it otherwise
    localparam int ROUND_NUM = 3;
    localparam int ROUND_DEN = 5;

endpackage
`default_nettype wire

/* rtl/rti_front.sv */
`default_nettype none
module rti_front #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_VALUES = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rti_pkg::in_item_t s_data,
    output logic                   q_valid,
    output rti_pkg::q_item_t       q_item,
    input  wire logic              q_pop
);
    import rti_pkg::*;

    localparam int ROW_WORDS = MAX_VALUES + 2;

    q_item_t    q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    q_item_t    item;

    // classify: out-of-range writes travel as drops
    always_comb begin
        item.row_sel    = s_data.row_sel;
        item.column_sel = s_data.column_sel;
        item.write_word = s_data.write_word;
        item.level      = s_data.level;
        if (s_data.req_type == REQ_LOOKUP) begin
            item.op = OP_LOOKUP;
        end else if (32'(s_data.row_sel) < MAX_ROWS &&
                     32'(s_data.column_sel) < ROW_WORDS) begin
            item.op = OP_WRITE;
        end else begin
            item.op = OP_DROP;
        end
    end

    assign s_ready    = (count_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = q_mem_reg[rd_ptr_reg];
    assign count_next = count_reg + {1'b0, push} - {1'b0, q_pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wr_ptr_reg] <= item;
    end

endmodule
`default_nettype wire

/* rtl/rti_back.sv */
`default_nettype none
module rti_back #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_VALUES = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [rti_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                        q_valid,
    input  wire rti_pkg::q_item_t            q_item,
    output logic                             q_pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output rti_pkg::out_item_t               m_data
);
    import rti_pkg::*;

    localparam int ROW_WORDS = MAX_VALUES + 2;
    localparam int DEPTH     = MAX_ROWS * ROW_WORDS;
    localparam int AW        = $clog2(DEPTH);
    localparam int RW        = $clog2(MAX_ROWS);
    localparam int CW        = $clog2(MAX_ROWS + 1);
    localparam int VW        = $clog2(MAX_VALUES + 1);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_RD_LO    = 13'b0000000000010,
        S_RD_HI    = 13'b0000000000100,
        S_CHK      = 13'b0000000001000,
        S_DECIDE   = 13'b0000000010000,
        S_VAL_RD   = 13'b0000000100000,
        S_VAL_WAIT = 13'b0000001000000,
        S_Y1_RD    = 13'b0000010000000,
        S_Y2_RD    = 13'b0000100000000,
        S_MUL      = 13'b0001000000000,
        S_DIV      = 13'b0010000000000,
        S_RND      = 13'b0100000000000,
        S_EMIT     = 13'b1000000000000
    } state_t;

    function automatic logic [AW-1:0] word_addr(input logic [RW-1:0] row, input int col);
        word_addr = AW'(int'(row) * ROW_WORDS + col);
    endfunction

    logic [15:0]   mem [DEPTH];
    logic [15:0]   rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    state_t        state_reg, state_next;
    logic [4:0]    rows_cfg_reg;
    logic [3:0]    vals_cfg_reg;
    logic [CW-1:0] rows_eff;
    logic [VW-1:0] vals_eff;

    logic [15:0]   lvl_reg, lo_reg, prev_lo_reg, upper0_reg, gx1_reg, gx2_reg, den_reg;
    logic [CW-1:0] row_reg;
    logic          hit_reg, gap_reg;
    logic [RW-1:0] hit_row_reg, gap_row_reg, sel_row_reg;
    logic [1:0]    status_reg;
    logic [VW-1:0] col_reg;
    logic [15:0]   y1_reg, res_reg;
    logic          up_reg, neg_reg;
    logic [31:0]   dvd_reg;
    logic [15:0]   rem_reg;
    logic [4:0]    div_cnt_reg;

    logic          m_valid_reg;
    out_item_t     m_data_reg;
    logic          out_free, out_load, col_last, scan_last;
    logic [1:0]    dec_status;
    logic [RW-1:0] dec_row;
    logic [16:0]   rem_sh;
    logic          div_bit;
    logic [15:0]   dx, dy_mag;
    logic [18:0]   r5, t5, d3;
    logic [15:0]   rnd_val;

    // clamp registers into their legal ranges
    always_comb begin
        if (rows_cfg_reg == 5'd0) rows_eff = CW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS) rows_eff = CW'(MAX_ROWS);
        else rows_eff = CW'(rows_cfg_reg);
        if (vals_cfg_reg == 4'd0) vals_eff = VW'(1);
        else if (32'(vals_cfg_reg) > MAX_VALUES) vals_eff = VW'(MAX_VALUES);
        else vals_eff = VW'(vals_cfg_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= ROWS_RESET;
            vals_cfg_reg <= VALUES_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_IDX_ROWS) rows_cfg_reg <= cfg_wdata;
            else vals_cfg_reg <= cfg_wdata[3:0];
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign col_last  = (32'(col_reg) + 1 == 32'(vals_eff));
    assign scan_last = (32'(row_reg) + 1 == 32'(rows_eff));
    assign rem_sh    = {rem_reg, dvd_reg[31]};
    assign div_bit   = (rem_sh >= {1'b0, den_reg});
    assign dx        = lvl_reg - gx1_reg;
    assign dy_mag    = (rdata_reg < y1_reg) ? (y1_reg - rdata_reg) : (rdata_reg - y1_reg);
    assign r5        = 19'(32'(rem_reg) * ROUND_DEN);
    assign t5        = 19'(32'(den_reg - rem_reg) * ROUND_DEN);
    assign d3        = 19'(32'(den_reg) * ROUND_NUM);

    // rounding of the quotient into the final value
    always_comb begin
        if (!neg_reg) begin
            if (up_reg ? (r5 >= d3) : (r5 > d3))
                rnd_val = y1_reg + dvd_reg[15:0] + 16'd1;
            else
                rnd_val = y1_reg + dvd_reg[15:0];
        end else if (rem_reg == 16'd0 || t5 > d3) begin
            rnd_val = y1_reg - dvd_reg[15:0];
        end else begin
            rnd_val = y1_reg - dvd_reg[15:0] - 16'd1;
        end
    end

    // pick the outcome of the scan in priority order
    always_comb begin
        dec_row = '0;
        priority if (hit_reg) begin
            dec_status = ST_COPY;
            dec_row    = hit_row_reg;
        end else if (lvl_reg >= upper0_reg) begin
            dec_status = ST_COPY;
        end else if (lvl_reg == 16'd0) begin
            dec_status = ST_COPY;
            dec_row    = RW'(rows_eff - CW'(1));
        end else if (gap_reg) begin
            dec_status = ST_INTERP;
            dec_row    = gap_row_reg;
        end else begin
            dec_status = ST_NOMATCH;
        end
    end

    always_comb begin
        state_next = state_reg;
        rd_addr    = '0;
        mem_we     = 1'b0;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    unique case (q_item.op)
                        OP_WRITE: begin
                            mem_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        OP_LOOKUP: state_next = S_RD_LO;
                        default:   q_pop = 1'b1;
                    endcase
                end
            end
            S_RD_LO: begin
                rd_addr    = word_addr(row_reg[RW-1:0], 0);
                state_next = S_RD_HI;
            end
            S_RD_HI: begin
                rd_addr    = word_addr(row_reg[RW-1:0], 1);
                state_next = S_CHK;
            end
            S_CHK:    state_next = scan_last ? S_DECIDE : S_RD_LO;
            S_DECIDE: begin
                unique case (dec_status)
                    ST_COPY:   state_next = S_VAL_RD;
                    ST_INTERP: state_next = S_Y1_RD;
                    default:   state_next = S_EMIT;
                endcase
            end
            S_VAL_RD: begin
                rd_addr    = word_addr(sel_row_reg, 2 + int'(col_reg));
                state_next = S_VAL_WAIT;
            end
            S_VAL_WAIT: state_next = S_EMIT;
            S_Y1_RD: begin
                rd_addr    = word_addr(sel_row_reg + RW'(1), 2 + int'(col_reg));
                state_next = S_Y2_RD;
            end
            S_Y2_RD: begin
                rd_addr    = word_addr(sel_row_reg, 2 + int'(col_reg));
                state_next = S_MUL;
            end
            S_MUL: state_next = S_DIV;
            S_DIV: if (div_cnt_reg == 5'd31) state_next = S_RND;
            S_RND: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (col_last) begin
                        q_pop      = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        unique case (status_reg)
                            ST_COPY:   state_next = S_VAL_RD;
                            ST_INTERP: state_next = S_Y1_RD;
                            default:   state_next = S_EMIT;
                        endcase
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we)
            mem[word_addr(RW'(q_item.row_sel), int'(q_item.column_sel))] <= q_item.write_word;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                lvl_reg <= q_item.level;
                row_reg <= '0;
                hit_reg <= 1'b0;
                gap_reg <= 1'b0;
            end
            S_RD_HI: lo_reg <= rdata_reg;
            S_CHK: begin
                if (row_reg == '0) upper0_reg <= rdata_reg;
                if (!hit_reg && lvl_reg > lo_reg && lvl_reg < rdata_reg) begin
                    hit_reg     <= 1'b1;
                    hit_row_reg <= row_reg[RW-1:0];
                end
                if (row_reg != '0 && !gap_reg && lvl_reg < prev_lo_reg &&
                    lvl_reg > rdata_reg) begin
                    gap_reg     <= 1'b1;
                    gap_row_reg <= row_reg[RW-1:0] - RW'(1);
                    gx1_reg     <= rdata_reg;
                    gx2_reg     <= prev_lo_reg;
                end
                prev_lo_reg <= lo_reg;
                row_reg     <= row_reg + CW'(1);
            end
            S_DECIDE: begin
                status_reg  <= dec_status;
                sel_row_reg <= dec_row;
                col_reg     <= '0;
                res_reg     <= 16'd0;
                den_reg     <= gx2_reg - gx1_reg;
            end
            S_VAL_WAIT: res_reg <= rdata_reg;
            S_Y2_RD:    y1_reg  <= rdata_reg;
            S_MUL: begin
                up_reg      <= rdata_reg > y1_reg;
                neg_reg     <= rdata_reg < y1_reg;
                dvd_reg     <= 32'(dx) * 32'(dy_mag);
                rem_reg     <= 16'd0;
                div_cnt_reg <= 5'd0;
            end
            S_DIV: begin
                // one quotient bit per cycle, shifted into the dividend
                rem_reg     <= div_bit ? 16'(rem_sh - {1'b0, den_reg}) : rem_sh[15:0];
                dvd_reg     <= {dvd_reg[30:0], div_bit};
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            S_RND: res_reg <= rnd_val;
            S_EMIT: if (out_load) col_reg <= col_reg + VW'(1);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.status       <= status_reg;
            m_data_reg.value_index  <= 3'(col_reg);
            m_data_reg.result_value <= res_reg;
            m_data_reg.last         <= col_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

/* rtl/range_table_interpolator.sv */
// A lookup scans the rows in use for the bounds (read low, read high and check per row),
// then decides and, per value column, copies a row value, interpolates (32-step restoring
// divider) or gives zero, then waits for the output handshake; a table write retires once at
// the head of the queue. One lookup at a time; a two-entry input queue keeps accepting while it has room.
// Synchronous active-low reset clears control state and sets the registers to 16 rows
// and 8 values; the table contents are not cleared.
`default_nettype none
module range_table_interpolator #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_VALUES = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [rti_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire rti_pkg::in_item_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output rti_pkg::out_item_t              m_data
);
    import rti_pkg::*;

    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    rti_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_VALUES (MAX_VALUES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    rti_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_VALUES (MAX_VALUES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

/* tb/range_table_checker.sv */
module range_table_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [4:0]         cfg_wdata,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire rti_pkg::in_item_t  s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire rti_pkg::out_item_t m_data,
    output int                      fail_count,
    output int                      pending_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import rti_pkg::*;

    logic [15:0] table_words [16][10];
    logic [4:0]  rows_reg;
    logic [3:0]  vals_reg;
    out_item_t   expected_results [$];

    assign pending_results = expected_results.size();

    function automatic logic [15:0] interpolate(int lvl, int x1, int y1, int x2, int y2);
        longint den;
        longint num;
        longint base;
        longint q;
        longint r;
        den = x2 - x1;
        num = longint'(lvl - x1) * longint'(y2 - y1);
        if (num >= 0) begin
            q = num / den;
            r = num % den;
            base = y1 + q;
            if (y2 > y1) begin
                if (5 * r >= 3 * den) base++;
            end else begin
                if (5 * r > 3 * den) base++;
            end
        end else begin
            q = (-num) / den;
            r = (-num) % den;
            if (r == 0) begin
                base = y1 - q;
            end else begin
                base = y1 - q - 1;
                if (5 * (den - r) > 3 * den) base++;
            end
        end
        return base[15:0];
    endfunction

    task automatic predict_lookup(input int lvl);
        int rows;
        int vals;
        int row;
        logic [1:0] st;
        out_item_t res;
        rows = (rows_reg < 1) ? 1 : (rows_reg > 16) ? 16 : int'(rows_reg);
        vals = (vals_reg < 1) ? 1 : (vals_reg > 8) ? 8 : int'(vals_reg);
        row = 0;
        st = ST_NOMATCH;
        for (int i = 0; i < rows; i++) begin
            if (lvl > table_words[i][0] && lvl < table_words[i][1]) begin
                row = i;
                st = ST_COPY;
                break;
            end
        end
        if (st == ST_NOMATCH) begin
            if (lvl >= table_words[0][1]) begin
                st = ST_COPY;
            end else if (lvl == 0) begin
                row = rows - 1;
                st = ST_COPY;
            end else begin
                for (int i = 0; i + 1 < rows; i++) begin
                    if (lvl < table_words[i][0] && lvl > table_words[i + 1][1]) begin
                        row = i;
                        st = ST_INTERP;
                        break;
                    end
                end
            end
        end
        for (int j = 0; j < vals; j++) begin
            res.status = st;
            res.value_index = j[2:0];
            res.last = (j + 1 == vals);
            if (st == ST_COPY)
                res.result_value = table_words[row][2 + j];
            else if (st == ST_INTERP)
                res.result_value = interpolate(lvl, table_words[row + 1][1],
                    table_words[row + 1][2 + j], table_words[row][0], table_words[row][2 + j]);
            else
                res.result_value = '0;
            expected_results.push_back(res);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= ROWS_RESET;
            vals_reg <= VALUES_RESET;
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_IDX_ROWS) rows_reg <= cfg_wdata;
                else vals_reg <= cfg_wdata[3:0];
            end
            if (s_valid && s_ready) begin
                if (s_data.req_type == REQ_LOOKUP)
                    predict_lookup(s_data.level);
                else if (s_data.column_sel < 10)
                    table_words[s_data.row_sel][s_data.column_sel] = s_data.write_word;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    if (m_data !== expected_results[0]) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, expected_results[0], m_data);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_results.pop_front());
                end
            end
        end
    end
endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rti_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       cfg_we = 0;
    logic       cfg_index = CFG_IDX_ROWS;
    logic [4:0] cfg_wdata = '0;
    logic       s_valid = 0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 0;
    out_item_t  m_data;
    int         fail_count;
    int         pending_results;
    longint     cycle_count = 0;
    bit         quiet_phase = 0;

    always #1 aclk = ~aclk;

    range_table_interpolator DUT (.*);
    range_table_checker checker_i (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("range_table_interpolator regression: fail");
            $finish;
        end
    end

    // result-side stall bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                m_ready <= 0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
        end
    end

    task automatic send(input in_item_t item);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_sender;
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic write_word(input int row, input int col, input int word);
        in_item_t item;
        item = '0;
        item.req_type = ~REQ_LOOKUP;
        item.row_sel = 4'(row);
        item.column_sel = 4'(col);
        item.write_word = 16'(word);
        item.level = 16'($urandom);
        send(item);
    endtask

    task automatic lookup(input int lvl);
        in_item_t item;
        item = '0;
        item.req_type = REQ_LOOKUP;
        item.row_sel = 4'($urandom);
        item.column_sel = 4'($urandom);
        item.write_word = 16'($urandom);
        item.level = 16'(lvl);
        send(item);
    endtask

    // wait for all results, then let a trailing write retire
    task automatic drain;
        idle_sender();
        while (pending_results != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_reg(input logic idx, input int value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= 5'(value);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // descending rows, bounds with gaps; steep or random values
    task automatic load_table(input bit extreme);
        int hi;
        int span;
        int gap;
        hi = extreme ? 65535 : $urandom_range(20000, 65535);
        for (int r = 0; r < 16; r++) begin
            span = $urandom_range(2, hi / (2 * (16 - r)) + 2);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, span);
            write_word(r, 1, hi);
            hi = hi - span;
            if (hi < 0) hi = 0;
            write_word(r, 0, hi);
            hi = hi - gap;
            if (hi < 0) hi = 0;
            for (int c = 2; c < 10; c++)
                write_word(r, c, extreme ? (((r + c) % 2) ? 65535 : 0) : $urandom);
        end
        write_word($urandom_range(0, 15), $urandom_range(10, 15), $urandom);
    endtask

    task automatic random_level_lookup;
        case ($urandom_range(0, 5))
            0: lookup(0);
            1: lookup(65535);
            default: lookup($urandom);
        endcase
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: full table, extreme values and levels
        load_table(1);
        lookup(0);
        lookup(65535);
        lookup(1);
        lookup(32768);
        lookup(65534);
        drain();
        set_reg(CFG_IDX_ROWS, 0);
        set_reg(CFG_IDX_VALUES, 0);
        lookup(0);
        lookup(40000);
        drain();
        set_reg(CFG_IDX_ROWS, 31);
        set_reg(CFG_IDX_VALUES, 15);
        lookup(0);
        lookup(12345);
        drain();

        load_table(0);
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            set_reg(CFG_IDX_ROWS, phase == 0 ? 1 : phase == 1 ? 16 : $urandom_range(0, 31));
            set_reg(CFG_IDX_VALUES, phase == 0 ? 8 : phase == 1 ? 1 : $urandom_range(0, 15));
            if (phase == 3) quiet_phase = 1;
            for (int k = 0; k < 15; k++) begin
                if ($urandom_range(0, 9) == 0)
                    write_word($urandom_range(0, 15), $urandom_range(2, 9), $urandom);
                random_level_lookup();
            end
            drain();
        end

        if (fail_count == 0)
            $display("range_table_interpolator regression: pass");
        else
            $display("range_table_interpolator regression: fail");
        $finish;
    end
endmodule

/* range_table_interpolator.f */
rtl/rti_pkg.sv
rtl/rti_front.sv
rtl/rti_back.sv
rtl/range_table_interpolator.sv
tb/range_table_checker.sv
tb/testbench.sv
